FILE: hw/rtl/rtcse_pkg.sv
// Shared types, register indexes and calendar helpers for the RTC epoch unit.
`default_nettype none

package rtcse_pkg;

   localparam int unsigned FifoDepth    = 2;
   localparam int unsigned FifoPtrWidth = $clog2(FifoDepth);
   localparam int unsigned FifoCntWidth = $clog2(FifoDepth + 1);

   localparam logic [7:0] CsrBinaryMode  = 8'd0;
   localparam logic [7:0] CsrMaxAttempts = 8'd1;

   localparam logic [7:0] MaxAttemptsReset = 8'd8;

   typedef struct packed {
      logic [7:0] century_raw;
      logic [7:0] year_raw;
      logic [7:0] month_raw;
      logic [7:0] day_raw;
      logic [7:0] weekday_raw;
      logic [7:0] hour_raw;
      logic [7:0] min_raw;
      logic [7:0] sec_raw;
   } req_word_type;

   typedef struct packed {
      logic [31:0] epoch_seconds;
      logic        gave_up;
      logic [7:0]  attempts_used;
   } rsp_word_type;

   // one conversion or give-up job, raw calendar bytes still undecoded
   typedef struct packed {
      logic       gave_up;
      logic [7:0] attempts;
      logic [7:0] sec_raw;
      logic [7:0] min_raw;
      logic [7:0] hour_raw;
      logic [7:0] day_raw;
      logic [7:0] month_raw;
      logic [7:0] year_raw;
   } job_type;

   typedef struct packed {
      logic    valid;
      job_type job;
   } job_push_type;

   typedef enum logic [2:0] {
      BK_IDLE,
      BK_DAYS,
      BK_HOURS,
      BK_MINS,
      BK_SECS,
      BK_EMIT
   } back_state_type;

   // BCD digits decode as high*10+low even when invalid (max 165)
   function automatic logic [7:0] decode_byte(input logic [7:0] v, input logic binary);
      logic [7:0] tens;
      tens = {4'b0, v[7:4]};
      if (binary) begin
         return v;
      end
      return 8'((tens << 3) + (tens << 1)) + {4'b0, v[3:0]};
   endfunction

   // days before the first of the month; zero outside 1..12
   function automatic logic [8:0] month_offset(input logic [7:0] month);
      logic [8:0] d;
      case (month)
         8'd1:    d = 9'd0;
         8'd2:    d = 9'd31;
         8'd3:    d = 9'd59;
         8'd4:    d = 9'd90;
         8'd5:    d = 9'd120;
         8'd6:    d = 9'd151;
         8'd7:    d = 9'd181;
         8'd8:    d = 9'd212;
         8'd9:    d = 9'd243;
         8'd10:   d = 9'd273;
         8'd11:   d = 9'd304;
         8'd12:   d = 9'd334;
         default: d = 9'd0;
      endcase
      return d;
   endfunction

endpackage

`default_nettype wire

FILE: hw/rtl/rtcse_front.sv
// Front end: pairs snapshots, compares them and counts failed pairs.
`default_nettype none

module rtcse_front (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic [7:0]             max_attempts,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire rtcse_pkg::req_word_type req_word,
   output rtcse_pkg::job_push_type     push,
   input  wire logic                   push_ready
);
   import rtcse_pkg::*;

   req_word_type held_ff;
   logic         have_first_ff, have_first_in;
   logic [7:0]   failed_ff, failed_in;
   logic         accept;
   logic         match;
   logic [7:0]   failed_next;
   logic         give_up;

   // a word may produce a job, so hold off whenever the queue is full
   assign req_ready   = push_ready;
   assign accept      = req_valid && req_ready;
   assign match       = (req_word == held_ff);
   assign failed_next = failed_ff + 8'd1;
   assign give_up     = (failed_next >= max_attempts);

   always_comb begin
      push.valid         = accept && have_first_ff && (match || give_up);
      push.job.gave_up   = !match;
      push.job.attempts  = match ? failed_ff : failed_next;
      push.job.sec_raw   = held_ff.sec_raw;
      push.job.min_raw   = held_ff.min_raw;
      push.job.hour_raw  = held_ff.hour_raw;
      push.job.day_raw   = held_ff.day_raw;
      push.job.month_raw = held_ff.month_raw;
      push.job.year_raw  = held_ff.year_raw;
   end

   always_comb begin
      have_first_in = have_first_ff;
      failed_in     = failed_ff;
      if (accept) begin
         have_first_in = !have_first_ff;
         if (have_first_ff) begin
            if (match || give_up) begin
               failed_in = 8'd0;
            end else begin
               failed_in = failed_next;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         have_first_ff <= 1'b0;
         failed_ff     <= 8'd0;
      end else begin
         have_first_ff <= have_first_in;
         failed_ff     <= failed_in;
      end
   end

   always_ff @(posedge clock) begin
      if (accept && !have_first_ff) begin
         held_ff <= req_word;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/rtcse_fifo.sv
// Short job queue between the front end and the conversion back end.
`default_nettype none

module rtcse_fifo (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire rtcse_pkg::job_push_type push,
   output logic                        push_ready,
   output logic                        pop_valid,
   input  wire logic                   pop_ready,
   output rtcse_pkg::job_type          pop_job
);
   import rtcse_pkg::*;

   job_type                   mem_ff [FifoDepth];
   logic [FifoPtrWidth-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [FifoPtrWidth-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [FifoCntWidth-1:0]   count_ff, count_in;
   logic                      do_push, do_pop;

   assign push_ready = (count_ff != FifoCntWidth'(FifoDepth));
   assign pop_valid  = (count_ff != '0);
   assign pop_job    = mem_ff[rd_ptr_ff];
   assign do_push    = push.valid && push_ready;
   assign do_pop     = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == FifoPtrWidth'(FifoDepth - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == FifoPtrWidth'(FifoDepth - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         mem_ff[wr_ptr_ff] <= push.job;
      end
   end

endmodule

`default_nettype wire

FILE: hw/rtl/rtcse_back.sv
// Back end: decodes a job and runs the days/hours/minutes/seconds sequence.
`default_nettype none

module rtcse_back (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   binary_mode,
   input  wire logic                   job_valid,
   output logic                        job_ready,
   input  wire rtcse_pkg::job_type     job,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rtcse_pkg::rsp_word_type     rsp_word
);
   import rtcse_pkg::*;

   back_state_type state_ff, state_in;

   logic        gave_up_ff, gave_up_in;
   logic [7:0]  attempts_ff, attempts_in;
   logic [7:0]  sec_ff, sec_in;
   logic [7:0]  min_ff, min_in;
   logic [7:0]  hour_ff, hour_in;
   logic [7:0]  day_ff, day_in;
   logic [7:0]  month_ff, month_in;
   logic [7:0]  year_ff, year_in;
   logic [31:0] acc_ff, acc_in;

   logic         rsp_valid_ff, rsp_valid_in;
   rsp_word_type rsp_word_ff, rsp_word_in;

   logic        out_free;
   logic        late;
   logic [8:0]  leap_days;
   logic [16:0] year_days;
   logic [31:0] days;
   logic [5:0]  mul_k;
   logic [7:0]  mul_add;
   logic [31:0] step;

   assign out_free  = !rsp_valid_ff || rsp_ready;
   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;
   assign job_ready = (state_ff == BK_IDLE);

   // days since 2000-01-01; day 0 wraps modulo 2^32
   assign late      = (month_ff >= 8'd3);
   assign leap_days = ({1'b0, year_ff} + {8'b0, late} + 9'd3) >> 2;
   assign year_days = {9'b0, year_ff} * 17'd365;
   assign days      = {24'b0, day_ff} - 32'd1 + {23'b0, month_offset(month_ff)}
                      + {23'b0, leap_days} + {15'b0, year_days};

   // shared multiply-add: acc * k + field
   always_comb begin
      case (state_ff)
         BK_HOURS: begin
            mul_k   = 6'd24;
            mul_add = hour_ff;
         end
         BK_MINS: begin
            mul_k   = 6'd60;
            mul_add = min_ff;
         end
         default: begin
            mul_k   = 6'd60;
            mul_add = sec_ff;
         end
      endcase
   end

   assign step = 32'(acc_ff * {26'b0, mul_k}) + {24'b0, mul_add};

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         BK_IDLE: begin
            if (job_valid) begin
               state_in = job.gave_up ? BK_EMIT : BK_DAYS;
            end
         end
         BK_DAYS:  state_in = BK_HOURS;
         BK_HOURS: state_in = BK_MINS;
         BK_MINS:  state_in = BK_SECS;
         BK_SECS:  state_in = BK_EMIT;
         BK_EMIT: begin
            if (out_free) begin
               state_in = BK_IDLE;
            end
         end
         default:  state_in = BK_IDLE;
      endcase
   end

   always_comb begin
      gave_up_in   = gave_up_ff;
      attempts_in  = attempts_ff;
      sec_in       = sec_ff;
      min_in       = min_ff;
      hour_in      = hour_ff;
      day_in       = day_ff;
      month_in     = month_ff;
      year_in      = year_ff;
      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      rsp_word_in  = rsp_word_ff;
      case (state_ff)
         BK_IDLE: begin
            gave_up_in  = job.gave_up;
            attempts_in = job.attempts;
            sec_in      = decode_byte(job.sec_raw, binary_mode);
            min_in      = decode_byte(job.min_raw, binary_mode);
            hour_in     = decode_byte(job.hour_raw, binary_mode);
            day_in      = decode_byte(job.day_raw, binary_mode);
            month_in    = decode_byte(job.month_raw, binary_mode);
            year_in     = decode_byte(job.year_raw, binary_mode);
            acc_in      = 32'd0;
         end
         BK_DAYS: acc_in = days;
         BK_HOURS, BK_MINS, BK_SECS: acc_in = step;
         BK_EMIT: begin
            if (out_free) begin
               rsp_valid_in              = 1'b1;
               rsp_word_in.epoch_seconds = gave_up_ff ? 32'd0 : acc_ff;
               rsp_word_in.gave_up       = gave_up_ff;
               rsp_word_in.attempts_used = attempts_ff;
            end
         end
         default: acc_in = acc_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= BK_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      gave_up_ff  <= gave_up_in;
      attempts_ff <= attempts_in;
      sec_ff      <= sec_in;
      min_ff      <= min_in;
      hour_ff     <= hour_in;
      day_ff      <= day_in;
      month_ff    <= month_in;
      year_ff     <= year_in;
      acc_ff      <= acc_in;
      rsp_word_ff <= rsp_word_in;
   end

endmodule

`default_nettype wire

FILE: hw/rtl/rtc_stable_read_to_epoch_unit.sv
// Top level of the RTC stable-read to epoch-seconds unit.
`default_nettype none

// Takes RTC snapshot words in pairs; a pair that matches on all eight bytes
// yields seconds since 2000-01-01 (BCD decoded unless binary_mode is set),
// and after max_attempts mismatching pairs a give-up word (epoch 0) is
// returned. The front end takes one input word per cycle while the two-entry
// job queue has room. The back end works on one job at a time: a conversion
// result goes through load and decode, days, then three multiply-add steps of
// one shared multiplier, then the output register; a give-up result goes
// through load and the output register. Results wait in an output register
// while later words are taken.
module rtc_stable_read_to_epoch_unit (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   csr_we,
   input  wire logic [7:0]             csr_index,
   input  wire logic [7:0]             csr_wdata,
   input  wire logic                   req_valid,
   output logic                        req_ready,
   input  wire rtcse_pkg::req_word_type req_word,
   output logic                        rsp_valid,
   input  wire logic                   rsp_ready,
   output rtcse_pkg::rsp_word_type     rsp_word
);
   import rtcse_pkg::*;

   logic         binary_mode_ff, binary_mode_in;
   logic [7:0]   max_attempts_ff, max_attempts_in;
   job_push_type push;
   logic         push_ready;
   logic         job_valid;
   logic         job_ready;
   job_type      job;

   always_comb begin
      binary_mode_in  = binary_mode_ff;
      max_attempts_in = max_attempts_ff;
      if (csr_we) begin
         case (csr_index)
            CsrBinaryMode:  binary_mode_in  = csr_wdata[0];
            CsrMaxAttempts: max_attempts_in = csr_wdata;
            default:        binary_mode_in  = binary_mode_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         binary_mode_ff  <= 1'b0;
         max_attempts_ff <= MaxAttemptsReset;
      end else begin
         binary_mode_ff  <= binary_mode_in;
         max_attempts_ff <= max_attempts_in;
      end
   end

   rtcse_front u_front (
      .clock        (clock),
      .reset        (reset),
      .max_attempts (max_attempts_ff),
      .req_valid    (req_valid),
      .req_ready    (req_ready),
      .req_word     (req_word),
      .push         (push),
      .push_ready   (push_ready)
   );

   rtcse_fifo u_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_ready (push_ready),
      .pop_valid  (job_valid),
      .pop_ready  (job_ready),
      .pop_job    (job)
   );

   rtcse_back u_back (
      .clock       (clock),
      .reset       (reset),
      .binary_mode (binary_mode_ff),
      .job_valid   (job_valid),
      .job_ready   (job_ready),
      .job         (job),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_word    (rsp_word)
   );

endmodule

`default_nettype wire

FILE: tb/sv/tb_rtc_stable_read_to_epoch_unit.sv
// Testbench for the RTC stable-read to epoch unit: paired snapshots in, checked epoch words out.
module tb_rtc_stable_read_to_epoch_unit;
   import rtcse_pkg::*;

   localparam logic [7:0] CsrNoSuchReg = 8'd2;
   localparam int DrainCycles = 32;
   localparam int IdlePct = 29;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_we = 1'b0;
   logic [7:0] csr_index = 8'd0;
   logic [7:0] csr_wdata = 8'd0;
   logic req_valid = 1'b0;
   logic req_ready;
   req_word_type req_word = '0;
   logic rsp_valid;
   logic rsp_ready = 1'b0;
   rsp_word_type rsp_word;

   rtc_stable_read_to_epoch_unit u_dut (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .rsp_word  (rsp_word)
   );

   initial begin
      forever #2 clock = ~clock;
   end

   // local copy of the block's registers and pairing state
   logic         cfg_binary = 1'b0;
   logic [7:0]   cfg_max_attempts = MaxAttemptsReset;
   req_word_type held_word;
   logic         pair_open = 1'b0;
   logic [7:0]   failed_pairs = 8'd0;

   int unsigned days_before_month [12] = '{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};

   req_word_type snapshot_queue[$];
   rsp_word_type epoch_words_due[$];
   int unsigned  words_sent = 0;
   int unsigned  words_taken = 0;
   int           mismatch_count = 0;
   logic         steady = 1'b0;
   logic         gen_odd = 1'b0;

   task automatic note_mismatch(input string msg);
      $display("ERROR: %s", msg);
      mismatch_count++;
   endtask

   function automatic int unsigned raw_to_bin(input logic [7:0] v);
      if (cfg_binary) begin
         return v;
      end
      return v[7:4] * 10 + v[3:0];
   endfunction

   // all arithmetic wraps at 32 bits, as in hardware
   function automatic int unsigned epoch_of(input req_word_type s);
      int unsigned sec, mins, hr, dy, mon, yr, mdays, late, days;
      sec   = raw_to_bin(s.sec_raw);
      mins  = raw_to_bin(s.min_raw);
      hr    = raw_to_bin(s.hour_raw);
      dy    = raw_to_bin(s.day_raw);
      mon   = raw_to_bin(s.month_raw);
      yr    = raw_to_bin(s.year_raw);
      late  = (mon >= 32'd3) ? 32'd1 : 32'd0;
      mdays = (mon >= 32'd1 && mon <= 32'd12) ? days_before_month[mon - 32'd1] : 32'd0;
      days  = dy - 32'd1 + mdays + (yr + late + 32'd3) / 32'd4 + 32'd365 * yr;
      return ((days * 32'd24 + hr) * 32'd60 + mins) * 32'd60 + sec;
   endfunction

   task automatic take_snapshot(input req_word_type w);
      rsp_word_type r;
      if (!pair_open) begin
         held_word = w;
         pair_open = 1'b1;
      end else begin
         pair_open = 1'b0;
         if (w == held_word) begin
            r.epoch_seconds = epoch_of(held_word);
            r.gave_up = 1'b0;
            r.attempts_used = failed_pairs;
            epoch_words_due.push_back(r);
            failed_pairs = 8'd0;
         end else begin
            failed_pairs = failed_pairs + 8'd1;
            // a zero limit gives up on the first mismatch
            if (failed_pairs >= cfg_max_attempts) begin
               r.epoch_seconds = 32'd0;
               r.gave_up = 1'b1;
               r.attempts_used = failed_pairs;
               epoch_words_due.push_back(r);
               failed_pairs = 8'd0;
            end
         end
      end
   endtask

   function automatic req_word_type snap(input logic [7:0] sec, input logic [7:0] mins,
                                         input logic [7:0] hr, input logic [7:0] wd,
                                         input logic [7:0] dy, input logic [7:0] mon,
                                         input logic [7:0] yr, input logic [7:0] cen);
      req_word_type s;
      s.sec_raw = sec;
      s.min_raw = mins;
      s.hour_raw = hr;
      s.weekday_raw = wd;
      s.day_raw = dy;
      s.month_raw = mon;
      s.year_raw = yr;
      s.century_raw = cen;
      return s;
   endfunction

   function automatic logic [7:0] enc(input int unsigned v);
      if (cfg_binary) begin
         return 8'(v);
      end
      return {4'(v / 10), 4'(v % 10)};
   endfunction

   function automatic req_word_type make_snapshot(input int wild_pct);
      req_word_type s;
      if ($urandom_range(99) < wild_pct) begin
         s = {$urandom, $urandom};
      end else begin
         s = snap(enc($urandom_range(59)), enc($urandom_range(59)), enc($urandom_range(23)),
                  enc($urandom_range(7, 1)), enc($urandom_range(31, 1)),
                  enc($urandom_range(12, 1)), enc($urandom_range(99)), enc(20));
      end
      return s;
   endfunction

   function automatic req_word_type flip_one_bit(input req_word_type s);
      logic [63:0] v;
      int b;
      v = s;
      b = $urandom_range(63);
      v[b] = ~v[b];
      return v;
   endfunction

   task automatic queue_word(input req_word_type w);
      snapshot_queue.push_back(w);
      gen_odd = ~gen_odd;
   endtask

   task automatic queue_mismatches(input int n, input int wild_pct);
      req_word_type a;
      repeat (n) begin
         a = make_snapshot(wild_pct);
         queue_word(a);
         queue_word(flip_one_bit(a));
      end
   endtask

   task automatic queue_random_pair(input int wild_pct);
      req_word_type a;
      if ($urandom_range(99) < 6) begin
         // lone word, breaks the pairing
         queue_word(make_snapshot(100));
      end else begin
         if (gen_odd) begin
            queue_word(make_snapshot(wild_pct));
         end
         if (cfg_max_attempts != 8'd0 && cfg_max_attempts <= 8'd16 && $urandom_range(99) < 3) begin
            queue_mismatches(cfg_max_attempts, wild_pct);
         end
         a = make_snapshot(wild_pct);
         queue_word(a);
         if ($urandom_range(99) < 60) begin
            queue_word(a);
         end else begin
            queue_word(flip_one_bit(a));
         end
      end
   endtask

   task automatic csr_write(input logic [7:0] idx, input logic [7:0] val);
      @(negedge clock);
      csr_we <= 1'b1;
      csr_index <= idx;
      csr_wdata <= val;
      @(negedge clock);
      csr_we <= 1'b0;
      if (idx == CsrBinaryMode) begin
         cfg_binary = val[0];
      end else if (idx == CsrMaxAttempts) begin
         cfg_max_attempts = val;
      end
   endtask

   task automatic wait_drained();
      while (snapshot_queue.size() != 0 || words_taken != words_sent ||
             epoch_words_due.size() != 0) begin
         @(posedge clock);
      end
      // a trailing word may leave no result but still be in flight
      repeat (DrainCycles) @(posedge clock);
   endtask

   task automatic run_phase(input logic [7:0] bin_w, input logic [7:0] max_w,
                            input int n_pairs, input int wild_pct);
      csr_write(CsrBinaryMode, bin_w);
      csr_write(CsrMaxAttempts, max_w);
      repeat (n_pairs) queue_random_pair(wild_pct);
      if (gen_odd) begin
         queue_word(make_snapshot(wild_pct));
      end
      wait_drained();
   endtask

   // driver: new word or idle at the falling edge, held until taken
   always @(negedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!(req_valid && words_taken != words_sent)) begin
         if (snapshot_queue.size() != 0 && (steady || $urandom_range(99) >= IdlePct)) begin
            req_word <= snapshot_queue.pop_front();
            req_valid <= 1'b1;
            words_sent <= words_sent + 1;
         end else begin
            req_valid <= 1'b0;
         end
      end
      rsp_ready <= steady || ($urandom_range(99) >= IdlePct);
   end

   // monitor: both channels sampled at the rising edge
   always @(posedge clock) begin : watch
      rsp_word_type want;
      if (!reset) begin
         if (req_valid && req_ready) begin
            take_snapshot(req_word);
            words_taken++;
         end
         if (rsp_valid && rsp_ready) begin
            if (epoch_words_due.size() == 0) begin
               note_mismatch($sformatf("unexpected word %h", rsp_word));
            end else begin
               want = epoch_words_due.pop_front();
               if (rsp_word.epoch_seconds !== want.epoch_seconds) begin
                  note_mismatch($sformatf("epoch_seconds %h, want %h",
                                          rsp_word.epoch_seconds, want.epoch_seconds));
               end
               if (rsp_word.gave_up !== want.gave_up) begin
                  note_mismatch($sformatf("gave_up %b, want %b", rsp_word.gave_up, want.gave_up));
               end
               if (rsp_word.attempts_used !== want.attempts_used) begin
                  note_mismatch($sformatf("attempts_used %0d, want %0d",
                                          rsp_word.attempts_used, want.attempts_used));
               end
            end
         end
      end
   end

   initial begin
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // directed, reset settings: BCD, limit 8
      queue_word(snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      queue_word(snap(8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00));
      queue_word(snap(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      queue_word(snap(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF));
      queue_word(snap(8'h00, 8'h00, 8'h00, 8'h06, 8'h01, 8'h01, 8'h00, 8'h20));
      queue_word(snap(8'h00, 8'h00, 8'h00, 8'h06, 8'h01, 8'h01, 8'h00, 8'h20));
      queue_word(snap(8'h59, 8'h59, 8'h23, 8'h05, 8'h31, 8'h12, 8'h99, 8'h20));
      queue_word(snap(8'h59, 8'h59, 8'h23, 8'h05, 8'h31, 8'h12, 8'h99, 8'h20));
      // leap day of 2000 and the day after
      queue_word(snap(8'h56, 8'h34, 8'h12, 8'h02, 8'h29, 8'h02, 8'h00, 8'h20));
      queue_word(snap(8'h56, 8'h34, 8'h12, 8'h02, 8'h29, 8'h02, 8'h00, 8'h20));
      queue_word(snap(8'h00, 8'h00, 8'h00, 8'h03, 8'h01, 8'h03, 8'h00, 8'h20));
      queue_word(snap(8'h00, 8'h00, 8'h00, 8'h03, 8'h01, 8'h03, 8'h00, 8'h20));
      // month 13
      queue_word(snap(8'h10, 8'h20, 8'h05, 8'h01, 8'h15, 8'h13, 8'h24, 8'h20));
      queue_word(snap(8'h10, 8'h20, 8'h05, 8'h01, 8'h15, 8'h13, 8'h24, 8'h20));
      // hour 24 and invalid BCD digits
      queue_word(snap(8'hAA, 8'h7F, 8'h24, 8'h07, 8'h3C, 8'h0B, 8'h9F, 8'h20));
      queue_word(snap(8'hAA, 8'h7F, 8'h24, 8'h07, 8'h3C, 8'h0B, 8'h9F, 8'h20));
      // mismatch on the compare-only bytes, then a match carries the count
      queue_word(snap(8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h20));
      queue_word(snap(8'h01, 8'h02, 8'h03, 8'h05, 8'h05, 8'h06, 8'h07, 8'h20));
      queue_word(snap(8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h20));
      queue_word(snap(8'h01, 8'h02, 8'h03, 8'h04, 8'h05, 8'h06, 8'h07, 8'h21));
      queue_word(snap(8'h45, 8'h30, 8'h18, 8'h04, 8'h04, 8'h07, 8'h24, 8'h20));
      queue_word(snap(8'h45, 8'h30, 8'h18, 8'h04, 8'h04, 8'h07, 8'h24, 8'h20));
      wait_drained();

      // zero limit, plus a write to an index that does not exist
      csr_write(CsrMaxAttempts, 8'd0);
      csr_write(CsrNoSuchReg, 8'hFF);
      queue_mismatches(1, 0);
      wait_drained();

      run_phase(8'h00, 8'h00, 40, 15);
      run_phase(8'h01, 8'h01, 120, 15);
      steady = 1'b1;
      run_phase(8'hFE, 8'h03, 120, 15);
      steady = 1'b0;

      // widest limit: one full burst of mismatches
      csr_write(CsrBinaryMode, 8'h00);
      csr_write(CsrMaxAttempts, 8'd255);
      repeat (60) queue_random_pair(15);
      if (gen_odd) begin
         queue_word(make_snapshot(15));
      end
      queue_mismatches(255, 15);
      repeat (15) queue_random_pair(15);
      if (gen_odd) begin
         queue_word(make_snapshot(15));
      end
      wait_drained();

      run_phase(8'h01, MaxAttemptsReset, 80, 15);
      run_phase(8'h00, MaxAttemptsReset, 80, 40);
      run_phase(8'h01, 8'h02, 80, 20);

      if (epoch_words_due.size() != 0) begin
         note_mismatch($sformatf("%0d results never came", epoch_words_due.size()));
      end
      if (mismatch_count == 0) begin
         $display("PASSED: all results match");
      end else begin
         $display("FAILED: results differ");
      end
      $finish;
   end

   // timeout, far beyond the slowest legal run
   initial begin
      #4000000;
      $display("FAILED: results differ");
      $finish;
   end

endmodule

FILE: filelist.f
hw/rtl/rtcse_pkg.sv
hw/rtl/rtcse_front.sv
hw/rtl/rtcse_fifo.sv
hw/rtl/rtcse_back.sv
hw/rtl/rtc_stable_read_to_epoch_unit.sv
tb/sv/tb_rtc_stable_read_to_epoch_unit.sv
